[sv/gwm_pkg.sv]
package gwm_pkg;

  // Pattern geometry
  localparam int PAT_LEN = 16;
  localparam int SET_W   = PAT_LEN + 1;
  localparam int LEN_W   = $clog2(PAT_LEN + 1);
  localparam int IDX_W   = $clog2(SET_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LEN_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN  = 2'd0,
    REG_PAT_LOW  = 2'd1,
    REG_PAT_HIGH = 2'd2
  } cfg_reg_t;

  // Wildcard bytes
  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef logic [SET_W-1:0] set_t;
  typedef logic [7:0]       pat_arr_t [PAT_LEN];

  // One input beat as carried through the input stage
  typedef struct packed {
    logic [7:0] text_byte;
    logic       no_char;
    logic       end_of_text;
  } gwm_item_t;

  // Star closure as a parallel prefix: bit j is set if some live bit i <= j
  // reaches j through a run of enabled stars at positions i..j-1.
  // prop[j] holds the star enable of position j-1.
  function automatic set_t close_set(set_t live, set_t prop);
    set_t g;
    set_t p;
    set_t g_n;
    set_t p_n;
    g = live;
    p = prop;
    for (int d = 1; d < SET_W; d = d * 2) begin
      g_n = g | (p & (g << d));
      p_n = p & (p << d);
      g   = g_n;
      p   = p_n;
    end
    return g;
  endfunction

endpackage

[sv/wildcard_glob_matcher.sv]
// Streaming glob matcher: text bytes enter one per beat on the in_ channel and,
// at the beat marked tlast, one beat leaves on the out_ channel with bit 0 set
// if the whole text matched the stored pattern ('*' any run, '?' any one byte,
// all else exact and case-sensitive). A beat with in_tuser set carries no
// character; with tlast it closes the text (an empty text if it is alone).
// The block takes one beat per cycle unless an end beat waits for the result
// slot; the tlast beat passes the input stage register, then the result
// register behind out_tvalid. The rate is set by the live-position update:
// a star closure, a byte compare per position, a second closure; combinational.
// Write the pattern registers only while no text is in flight.
module wildcard_glob_matcher import gwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_byte
  input  logic [0:0]            in_tuser,   // [0] no_char
  input  logic                  in_tlast,   // end_of_text
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] matched, [7:1] zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_LEN_W-1:0] pat_len_r;
  logic [7:0]           pat_r [PAT_LEN];
  logic [LEN_W-1:0]     eff_len;

  logic                 s1_valid_r;
  gwm_item_t            s1_item_r;
  logic                 s1_go;
  logic                 in_acc;

  set_t                 live_r;
  set_t                 live_nxt;
  logic                 step_match;

  logic                 out_valid_r;
  logic                 matched_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      for (int i = 0; i < PAT_LEN; i++) pat_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT_LEN:  pat_len_r <= cfg_data[CFG_LEN_W-1:0];
        REG_PAT_LOW: begin
          for (int i = 0; i < 8; i++) pat_r[i] <= cfg_data[8*i +: 8];
        end
        REG_PAT_HIGH: begin
          for (int i = 8; i < PAT_LEN; i++) pat_r[i] <= cfg_data[8*(i-8) +: 8];
        end
        default: ;
      endcase
    end
  end

  // Saturate the length to the pattern size
  assign eff_len = (pat_len_r > CFG_LEN_W'(PAT_LEN)) ? LEN_W'(PAT_LEN)
                                                     : LEN_W'(pat_len_r);

  // Input stage: a beat leaves when it ends no text or the result slot frees up
  assign s1_go     = s1_valid_r &&
                     (!s1_item_r.end_of_text || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.text_byte   <= in_tdata;
      s1_item_r.no_char     <= in_tuser[0];
      s1_item_r.end_of_text <= in_tlast;
    end
  end

  // Live-position update
  gwm_step u_step (
    .live      (live_r),
    .item      (s1_item_r),
    .pat       (pat_r),
    .eff_len   (eff_len),
    .live_next (live_nxt),
    .matched   (step_match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= set_t'(1);
    end else if (s1_go) begin
      live_r <= live_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.end_of_text) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.end_of_text) begin
      matched_r <= step_match;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, matched_r};

  // Checks
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_item_r.end_of_text) |=> (live_r == set_t'(1)))
    else $error("live set not restarted after end of text");

  a_nochar_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_item_r.no_char && !s1_item_r.end_of_text) |=> $stable(live_r))
    else $error("empty beat changed the live set");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_item_r.end_of_text))
    else $error("result appeared without an end beat");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.end_of_text && out_valid_r && !out_tready)
      |-> (!in_tready && !s1_go))
    else $error("end beat processed while result slot full");

endmodule

[sv/gwm_step.sv]
module gwm_step import gwm_pkg::*; (
  input  set_t            live,
  input  gwm_item_t       item,
  input  logic [7:0]      pat [PAT_LEN],
  input  logic [LEN_W-1:0] eff_len,
  output set_t            live_next,
  output logic            matched
);

  set_t star_prop;
  set_t closed_cur;
  set_t adv;
  set_t after_char;
  set_t closed_end;

  // Star enables shifted up one place, limited to positions below the length
  always_comb begin
    star_prop = '0;
    for (int i = 0; i < PAT_LEN; i++) begin
      star_prop[i+1] = (pat[i] == STAR_BYTE) && (i < int'(eff_len));
    end
  end

  assign closed_cur = close_set(live, star_prop);

  // Advance every live position by the character
  always_comb begin
    adv = '0;
    for (int i = 0; i < PAT_LEN; i++) begin
      if (closed_cur[i] && (i < int'(eff_len))) begin
        if (pat[i] == STAR_BYTE) begin
          adv[i] = 1'b1;
        end else if (pat[i] == QMARK_BYTE || pat[i] == item.text_byte) begin
          adv[i+1] = 1'b1;
        end
      end
    end
  end

  assign after_char = item.no_char ? live : adv;
  assign closed_end = close_set(after_char, star_prop);
  assign matched    = closed_end[eff_len[IDX_W-1:0]];

  // End of text returns to the start set
  assign live_next = item.end_of_text ? set_t'(1) : after_char;

endmodule
